[rtl/cbor_stream_tokenizer_top_defines.svh]
// Assertion macros shared by the tokenizer modules
`ifndef CBOR_STREAM_TOKENIZER_TOP_DEFINES_SVH
`define CBOR_STREAM_TOKENIZER_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define CST_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbor tokenizer check failed");

// Implication with the consequent checked in the next cycle
`define CST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbor tokenizer check failed");

`endif

[rtl/cst_pkg.sv]
`timescale 1ns / 1ps
package cst_pkg;

    localparam int NEST_DEPTH = 16;
    localparam int LVL_W = $clog2(NEST_DEPTH + 1);
    localparam int IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    localparam logic [4:0] INFO_MASK = 5'h1F;
    localparam logic [4:0] INFO_ARG1 = 5'd24;
    localparam logic [4:0] INFO_ARG8 = 5'd27;

    localparam logic [1:0] KIND_HEAD = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_END = 3'd1;
    localparam logic [2:0] ERR_TRUNC_ARG = 3'd2;
    localparam logic [2:0] ERR_STR_SHORT = 3'd3;
    localparam logic [2:0] ERR_INDEF = 3'd4;
    localparam logic [2:0] ERR_BAD_MAJOR = 3'd5;
    localparam logic [2:0] ERR_KEY_TYPE = 3'd6;
    localparam logic [2:0] ERR_DEEP = 3'd7;

    localparam logic [2:0] MAJ_UINT = 3'd0;
    localparam logic [2:0] MAJ_NINT = 3'd1;
    localparam logic [2:0] MAJ_BSTR = 3'd2;
    localparam logic [2:0] MAJ_TSTR = 3'd3;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;
    localparam logic [2:0] MAJ_MAP = 3'd5;
    localparam logic [2:0] MAJ_TAG = 3'd6;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  major;
        logic [63:0] argument;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [4:0]  nesting_level;
        logic        in_key_position;
        logic [4:0]  containers_closed;
        logic        value_done;
        logic [2:0]  error_code;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_HEAD,
        ST_ARG,
        ST_STRING,
        ST_POP,
        ST_DONE,
        ST_ERROR,
        ST_OUT
    } state_t;

    // Work phase of the controller
    typedef enum logic [1:0] { PH_IDLE, PH_EVAL, PH_POP } phase_t;

    // Controller to datapath
    typedef struct packed {
        logic load_byte;    // capture input item
        logic arg_start;    // load short-form argument or clear accumulator, load byte count
        logic arg_shift;    // shift in one argument byte
        logic str_load;     // load string count from argument
        logic str_dec;
        logic push;
        logic pop_step;     // one step of container completion
        logic pop_init;     // clear closed counter
        logic clear;        // reset stack level and closed counter
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       arg_last;   // final argument byte in hand
        logic       str_last;   // string count is one
        logic       level_zero;
        logic       level_full;
        logic       top_key;    // top is a map expecting a key
        logic       top_ends;   // top remaining count is one
    } stat_t;

endpackage

[rtl/cbor_stream_tokenizer_top.sv]
`timescale 1ns / 1ps
// CBOR stream tokenizer, definite-length subset.
// Input channel in_valid/in_stall carries one byte of the buffer per item
// with a flag on its last byte. Output channel out_valid/out_stall carries
// at most one result item per input byte: a completed head, a string payload
// byte, or an error.
// Each byte is captured, then evaluated in the next cycle. A byte that
// opens a string or container takes one more step (one stack or counter
// update), and a byte that completes an item then walks the nesting stack
// one entry per cycle as it closes containers. The result register is then
// offered on the output.
// Input is stalled while a byte is being worked on and while the receiver
// holds off a waiting result, so a receiver stall holds the whole block;
// nothing is dropped.
// Reset (rst_n low, asynchronous) returns the parser to expecting a head
// with an empty stack. The last byte of a buffer resets it the same way.
// After an error, or after the top-level value completes, further bytes
// give no result until the last byte.
module cbor_stream_tokenizer_top import cst_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    cmd_t             cmd;
    stat_t            stat;
    logic [7:0]       byte_q;
    logic             last_q;
    logic [2:0]       major_q;
    logic [63:0]      arg_q;
    logic [LVL_W-1:0] level_q;
    logic [4:0]       closed_q;
    logic             key_q;

    cst_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .stat     (stat),
        .byte_q   (byte_q),
        .last_q   (last_q),
        .major_q  (major_q),
        .arg_q    (arg_q),
        .level_q  (level_q),
        .closed_q (closed_q),
        .key_q    (key_q)
    );

    cst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat),
        .byte_q    (byte_q),
        .last_q    (last_q),
        .major_q   (major_q),
        .arg_q     (arg_q),
        .level_q   (level_q),
        .closed_q  (closed_q),
        .key_q     (key_q)
    );

endmodule

[rtl/cst_datapath.sv]
`timescale 1ns / 1ps
`include "cbor_stream_tokenizer_top_defines.svh"
module cst_datapath import cst_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  in_item_t    in_item,
    output stat_t       stat,
    output logic [7:0]  byte_q,
    output logic        last_q,
    output logic [2:0]  major_q,
    output logic [63:0] arg_q,
    output logic [LVL_W-1:0] level_q,
    output logic [4:0]  closed_q,
    output logic        key_q
);

    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [2:0]       major_reg;
    logic [63:0]      arg_reg;
    logic [3:0]       arg_left_reg;
    logic [63:0]      str_left_reg;
    logic [LVL_W-1:0] level_reg;
    logic [4:0]       closed_reg;

    logic [63:0] rem_mem [NEST_DEPTH];
    logic        map_mem [NEST_DEPTH];
    logic        key_mem [NEST_DEPTH];

    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] push_idx;

    assign top = IDX_W'(level_reg - LVL_W'(1));
    assign push_idx = IDX_W'(level_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            closed_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
                level_reg <= '0;
            else if (cmd.push)
                level_reg <= level_reg + LVL_W'(1);
            else if (cmd.pop_step && !(map_mem[top] && key_mem[top]) && rem_mem[top] == 64'd1)
                level_reg <= level_reg - LVL_W'(1);
            if (cmd.pop_init || cmd.clear)
                closed_reg <= '0;
            else if (cmd.pop_step && !(map_mem[top] && key_mem[top]) && rem_mem[top] == 64'd1)
                closed_reg <= closed_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= in_item.data_byte;
            last_reg <= in_item.last_byte;
        end
        if (cmd.arg_start)
        begin
            major_reg <= byte_reg[7:5];
            // short form keeps the info as argument; long form starts from zero
            arg_reg <= (byte_reg[4:0] < INFO_ARG1) ? 64'(byte_reg[4:0] & INFO_MASK) : 64'd0;
            arg_left_reg <= 4'd1 << (byte_reg[1:0]);
        end
        else if (cmd.arg_shift)
        begin
            arg_reg <= {arg_reg[55:0], byte_reg};
            arg_left_reg <= arg_left_reg - 4'd1;
        end
        if (cmd.str_load)
            str_left_reg <= arg_reg;
        else if (cmd.str_dec)
            str_left_reg <= str_left_reg - 64'd1;
        if (cmd.push)
        begin
            rem_mem[push_idx] <= arg_reg;
            map_mem[push_idx] <= (major_reg == MAJ_MAP);
            key_mem[push_idx] <= (major_reg == MAJ_MAP);
        end
        else if (cmd.pop_step)
        begin
            if (map_mem[top] && key_mem[top])
                key_mem[top] <= 1'b0;
            else
            begin
                rem_mem[top] <= rem_mem[top] - 64'd1;
                key_mem[top] <= map_mem[top];
            end
        end
    end

    always_comb
    begin
        stat.arg_last = (arg_left_reg == 4'd1);
        stat.str_last = (str_left_reg == 64'd1);
        stat.level_zero = (level_reg == '0);
        stat.level_full = (level_reg >= LVL_W'(NEST_DEPTH));
        stat.top_key = (level_reg != '0) && map_mem[top] && key_mem[top];
        stat.top_ends = (rem_mem[top] == 64'd1);
    end

    assign byte_q = byte_reg;
    assign last_q = last_reg;
    assign major_q = major_reg;
    assign arg_q = arg_reg;
    assign level_q = level_reg;
    assign closed_q = closed_reg;
    assign key_q = stat.top_key;

    `CST_ASSERT(a_level_bound, 1'b1, level_reg <= LVL_W'(NEST_DEPTH))
    `CST_ASSERT(a_push_room, cmd.push, level_reg < LVL_W'(NEST_DEPTH))
    `CST_ASSERT_NEXT(a_clear_level, cmd.clear, level_reg == '0)

endmodule

[rtl/cst_ctrl.sv]
`timescale 1ns / 1ps
`include "cbor_stream_tokenizer_top_defines.svh"
module cst_ctrl import cst_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    output cmd_t        cmd,
    input  stat_t       stat,
    input  logic [7:0]  byte_q,
    input  logic        last_q,
    input  logic [2:0]  major_q,
    input  logic [63:0] arg_q,
    input  logic [LVL_W-1:0] level_q,
    input  logic [4:0]  closed_q,
    input  logic        key_q
);

    // mode_reg: parse mode kept between bytes; phase_reg: work phase
    state_t    mode_reg, mode_next;
    phase_t    phase_reg, phase_next;
    logic      ovalid_reg, ovalid_next;
    out_item_t obuf_reg, obuf_next;
    logic      str_kind_reg, str_kind_next;   // set when an item completes, clear after a string or container head
    logic      hkey_reg, hkey_next;

    logic        accept;
    logic [2:0]  bmaj;
    logic [4:0]  binfo;
    logic        is_head;
    logic [2:0]  hmaj;
    logic [63:0] harg;

    // a result leaving this cycle frees the input in the same cycle
    assign in_stall = (phase_reg != PH_IDLE) || (ovalid_reg && out_stall);
    assign accept = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_item = obuf_reg;
    assign bmaj = byte_q[7:5];
    assign binfo = byte_q[4:0] & INFO_MASK;

    function automatic out_item_t err_item(input logic [2:0] code);
        out_item_t o;
        o = '0;
        o.kind = KIND_ERROR;
        o.error_code = code;
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ST_HEAD;
            phase_reg <= PH_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            phase_reg <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obuf_reg <= obuf_next;
        str_kind_reg <= str_kind_next;
        hkey_reg <= hkey_next;
    end

    always_comb
    begin
        mode_next = mode_reg;
        phase_next = phase_reg;
        ovalid_next = ovalid_reg && out_stall;
        obuf_next = obuf_reg;
        str_kind_next = str_kind_reg;
        hkey_next = hkey_reg;
        cmd = '0;
        is_head = 1'b0;
        hmaj = major_q;
        harg = arg_q;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_byte = 1'b1;
                    phase_next = PH_EVAL;
                end
            end
            PH_EVAL:
            begin
                phase_next = PH_IDLE;
                unique case (mode_reg)
                    ST_HEAD:
                    begin
                        cmd.arg_start = 1'b1;
                        if (binfo < INFO_ARG1)
                        begin
                            is_head = 1'b1;
                            hmaj = bmaj;
                            harg = 64'(binfo);
                        end
                        else if (binfo <= INFO_ARG8)
                        begin
                            mode_next = ST_ARG;
                            if (last_q)
                            begin
                                obuf_next = err_item(ERR_TRUNC_ARG);
                                ovalid_next = 1'b1;
                            end
                        end
                        else
                        begin
                            mode_next = ST_ERROR;
                            obuf_next = err_item(ERR_INDEF);
                            ovalid_next = 1'b1;
                        end
                    end
                    ST_ARG:
                    begin
                        cmd.arg_shift = 1'b1;
                        if (stat.arg_last)
                        begin
                            is_head = 1'b1;
                            harg = {arg_q[55:0], byte_q};
                        end
                        else if (last_q)
                        begin
                            mode_next = ST_ERROR;
                            obuf_next = err_item(ERR_TRUNC_ARG);
                            ovalid_next = 1'b1;
                        end
                    end
                    ST_STRING:
                    begin
                        cmd.str_dec = 1'b1;
                        obuf_next = '0;
                        obuf_next.kind = KIND_PAYLOAD;
                        obuf_next.major = major_q;
                        obuf_next.payload_byte = byte_q;
                        obuf_next.nesting_level = 5'(level_q);
                        obuf_next.in_key_position = key_q;
                        if (!stat.str_last)
                        begin
                            if (last_q)
                            begin
                                mode_next = ST_ERROR;
                                obuf_next = err_item(ERR_STR_SHORT);
                            end
                            ovalid_next = 1'b1;
                        end
                        else
                        begin
                            obuf_next.payload_last = 1'b1;
                            str_kind_next = 1'b1;
                            cmd.pop_init = 1'b1;
                            phase_next = PH_POP;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // Head complete: argument in harg, major in hmaj
                if (is_head)
                begin
                    obuf_next = '0;
                    obuf_next.kind = KIND_HEAD;
                    obuf_next.major = hmaj;
                    obuf_next.argument = harg;
                    obuf_next.nesting_level = 5'(level_q);
                    obuf_next.in_key_position = key_q;
                    mode_next = ST_HEAD;
                    if (hmaj == MAJ_NINT || hmaj == MAJ_TAG || hmaj == MAJ_SIMPLE)
                    begin
                        mode_next = ST_ERROR;
                        obuf_next = err_item(ERR_BAD_MAJOR);
                        ovalid_next = 1'b1;
                    end
                    else if (key_q && hmaj != MAJ_TSTR)
                    begin
                        mode_next = ST_ERROR;
                        obuf_next = err_item(ERR_KEY_TYPE);
                        ovalid_next = 1'b1;
                    end
                    else if ((hmaj == MAJ_BSTR || hmaj == MAJ_TSTR) && harg != 64'd0)
                    begin
                        mode_next = ST_STRING;
                        // arg register holds harg on next cycle
                        phase_next = PH_POP;
                        str_kind_next = 1'b0;
                        hkey_next = 1'b1;
                        if (last_q)
                        begin
                            mode_next = ST_ERROR;
                            obuf_next = err_item(ERR_STR_SHORT);
                            phase_next = PH_IDLE;
                        end
                        ovalid_next = 1'b1;
                    end
                    else if ((hmaj == MAJ_ARRAY || hmaj == MAJ_MAP) && harg != 64'd0)
                    begin
                        phase_next = PH_POP;
                        str_kind_next = 1'b0;
                        hkey_next = 1'b0;
                        if (stat.level_full)
                        begin
                            mode_next = ST_ERROR;
                            obuf_next = err_item(ERR_DEEP);
                            phase_next = PH_IDLE;
                            ovalid_next = 1'b1;
                        end
                        else if (last_q)
                        begin
                            mode_next = ST_ERROR;
                            obuf_next = err_item(ERR_END);
                            phase_next = PH_IDLE;
                            ovalid_next = 1'b1;
                        end
                        else
                            ovalid_next = 1'b1;
                    end
                    else
                    begin
                        // scalar or empty item: completes now
                        str_kind_next = 1'b1;
                        cmd.pop_init = 1'b1;
                        phase_next = PH_POP;
                    end
                end
            end
            PH_POP:
            begin
                if (!str_kind_reg)
                begin
                    // finish a string or container head with one bookkeeping step
                    if (hkey_reg)
                        cmd.str_load = 1'b1;
                    else
                        cmd.push = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (stat.level_zero)
                begin
                    obuf_next.containers_closed = closed_q;
                    obuf_next.value_done = 1'b1;
                    mode_next = ST_DONE;
                    ovalid_next = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    cmd.pop_step = 1'b1;
                    if (stat.top_key || !stat.top_ends)
                    begin
                        obuf_next.containers_closed = closed_q;
                        mode_next = ST_HEAD;
                        if (last_q)
                        begin
                            mode_next = ST_ERROR;
                            obuf_next = err_item(ERR_END);
                        end
                        ovalid_next = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // last byte of buffer restarts the parser once its work is done
        if (phase_reg != PH_IDLE && phase_next == PH_IDLE && last_q)
        begin
            mode_next = ST_HEAD;
            cmd.clear = 1'b1;
        end
    end

    `CST_ASSERT(a_no_accept_busy, phase_reg != PH_IDLE, in_stall)
    `CST_ASSERT_NEXT(a_hold_out, ovalid_reg && out_stall, ovalid_reg && $stable(obuf_reg))
    `CST_ASSERT(a_idle_mode, phase_reg == PH_IDLE, mode_reg != ST_POP && mode_reg != ST_OUT)

endmodule
